@@ rtl/crt_pkg.sv @@
// shared types and constants of the chunk reassembly tracker
`default_nettype none
package crt_pkg;

	// bytes of chunk header counted in packet_size
	localparam logic [15:0] HDR_BYTES = 16'd12;

	// assembly slots, sized to the two-bit slot field of the result
	localparam int SLOTS = 4;

	// func codes
	localparam logic FUNC_CHUNK   = 1'b0;
	localparam logic FUNC_CONSUME = 1'b1;

	// register index as decoded from paddr[2]
	localparam logic REG_STALE_WINDOW = 1'b0;

	localparam logic [1:0] STALE_WINDOW_RESET = 2'd3;

	typedef enum logic [2:0] {
		V_SHORT     = 3'd0,
		V_STALE     = 3'd1,
		V_BAD_INDEX = 3'd2,
		V_DUPLICATE = 3'd3,
		V_STORED    = 3'd4,
		V_COMPLETE  = 3'd5,
		V_CONSUMED  = 3'd6
	} verdict_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_EVICT,
		S_FIND,
		S_INDEX,
		S_DUP,
		S_ALLOC,
		S_OLDEST,
		S_REPLACE,
		S_STORE,
		S_FREE,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

@@ rtl/crt_in_if.sv @@
// chunk header channel: valid/ready handshake with the header fields
`default_nettype none
interface crt_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] frame_num;
	logic [15:0] chunk_index;
	logic [15:0] chunk_total;
	logic [31:0] claimed_len;
	logic [15:0] packet_size;

	modport source (
		output valid, func, frame_num, chunk_index, chunk_total, claimed_len, packet_size,
		input  ready
	);
	modport sink (
		input  valid, func, frame_num, chunk_index, chunk_total, claimed_len, packet_size,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/crt_out_if.sv @@
// result channel: valid/ready handshake with the verdict fields
`default_nettype none
interface crt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [1:0]  slot;
	logic [15:0] stored_length;
	logic        frame_done;
	logic        display_updated;
	logic        pending_valid;
	logic [31:0] pending_num;

	modport source (
		output valid, verdict, slot, stored_length, frame_done, display_updated,
		       pending_valid, pending_num,
		input  ready
	);
	modport sink (
		input  valid, verdict, slot, stored_length, frame_done, display_updated,
		       pending_valid, pending_num,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/chunk_reassembly_tracker.sv @@
// chunk reassembly tracker: slot bookkeeping, sequencer and apb register port
`default_nettype none
// Follows frames that arrive as numbered chunks. Each chunk header on the
// chunk channel gets one item on the result channel: short, stale, bad index,
// duplicate, stored, or stored and completed; a consume request (func = 1)
// clears the pending display flag and answers consumed. Chunk payload itself
// lives outside, addressed by the returned slot and the chunk index. A small
// sequencer walks the SLOTS assembly slots one per cycle through a single
// shared 32-bit subtract/compare unit: eviction of slots lagging a newer frame
// id, lookup of the frame's slot, the oldest-slot search when all slots are
// busy, and release of older slots once a frame completes. The chunk bitmaps
// sit in a SLOTS x MAX_CHUNKS memory with one registered read port, read in
// the state before the duplicate test. A finished result sits in an output
// register, so the next chunk is taken while the previous result still waits.
// stale_window is written over the apb port at byte address 0 (reset 3); the
// user must write it only while the block is idle, and the block itself does
// not enforce this.
module chunk_reassembly_tracker #(
	parameter int MAX_CHUNKS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	crt_in_if.sink      chunk,
	crt_out_if.source   result,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import crt_pkg::*;

	localparam int SW  = $clog2(SLOTS);          // slot index bits
	localparam int CIW = $clog2(MAX_CHUNKS);     // chunk index bits
	localparam int TW  = $clog2(MAX_CHUNKS + 1); // chunk count bits

	// control state
	state_t            state_q, state_d;
	logic [SW-1:0]     idx_q;
	logic [SLOTS-1:0]  in_use_q;
	logic [31:0]       newest_q;
	logic              pend_flag_q;
	logic [31:0]       pend_id_q;
	logic [1:0]        win_q;
	logic              out_valid_q;

	// captured item
	logic              func_q;
	logic [31:0]       fid_q;
	logic [15:0]       cidx_q;
	logic [15:0]       total_q;
	logic [31:0]       plen_q;
	logic [15:0]       psize_q;

	// slot table (ids and totals written on allocation, receive counts on store)
	logic [31:0]       slot_fid_q   [SLOTS];
	logic [TW-1:0]     slot_total_q [SLOTS];
	logic [TW-1:0]     slot_rcv_q   [SLOTS];

	// chunk bitmap memory, one row per slot
	logic [MAX_CHUNKS-1:0] map_mem [SLOTS];
	logic [MAX_CHUNKS-1:0] map_rd_q;

	// scan results and working values
	logic              found_q;
	logic              free_found_q;
	logic [SW-1:0]     slot_q;
	logic [SW-1:0]     free_q;
	logic [SW-1:0]     old_q;
	logic [31:0]       oldest_q;
	logic              alloc_q;
	logic [15:0]       len_q;

	// result being built and the output register
	verdict_t          res_verdict_q;
	logic              res_done_q;
	logic              res_upd_q;
	verdict_t          out_verdict_q;
	logic [SW-1:0]     out_slot_q;
	logic [15:0]       out_len_q;
	logic              out_done_q;
	logic              out_upd_q;
	logic              out_pend_q;
	logic [31:0]       out_pend_id_q;

	// shared subtract/compare unit
	logic [31:0]       unit_a, unit_b;
	logic [32:0]       unit_diff;
	logic              u_lt, u_eq, u_over;

	logic              accept;
	logic              last;
	logic              out_free;
	logic              cfg_wr;
	logic [15:0]       tot_sel;
	logic              idx_bad;
	logic [15:0]       room;
	logic [TW-1:0]     rcv_new;
	logic              cmp_done;
	logic [MAX_CHUNKS-1:0] row_new;
	logic [SW-1:0]     alloc_slot;
	logic              do_alloc;

	assign accept   = chunk.valid && chunk.ready;
	assign last     = (idx_q == SW'(SLOTS - 1));
	assign out_free = !out_valid_q || result.ready;
	assign chunk.ready = (state_q == S_IDLE);

	// apb register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STALE_WINDOW);
	assign prdata = (paddr[2] == REG_STALE_WINDOW) ? {30'd0, win_q} : 32'd0;

	// operand selection for the shared unit, one comparison per cycle
	always_comb begin
		unit_a = newest_q;
		unit_b = fid_q;
		case (state_q)
			S_CHECK: begin
				unit_a = newest_q;
				unit_b = fid_q;
			end
			S_EVICT: begin
				unit_a = newest_q;
				unit_b = slot_fid_q[idx_q];
			end
			S_FIND, S_FREE: begin
				unit_a = slot_fid_q[idx_q];
				unit_b = fid_q;
			end
			S_OLDEST: begin
				unit_a = slot_fid_q[idx_q];
				unit_b = oldest_q;
			end
			S_REPLACE: begin
				unit_a = oldest_q;
				unit_b = fid_q;
			end
			S_STORE: begin
				unit_a = pend_id_q;
				unit_b = fid_q;
			end
			default: begin
				unit_a = newest_q;
				unit_b = fid_q;
			end
		endcase
	end

	assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
	assign u_lt      = unit_diff[32];
	assign u_eq      = (unit_diff[31:0] == 32'd0);
	assign u_over    = (unit_diff[31:0] > {30'd0, win_q});

	// index check against the frame's total (stored one wins over the header)
	assign tot_sel = found_q ? 16'(slot_total_q[slot_q]) : total_q;
	assign idx_bad = (tot_sel > 16'(MAX_CHUNKS)) || (cidx_q >= tot_sel)
	               || (cidx_q >= 16'(MAX_CHUNKS));
	assign room    = psize_q - HDR_BYTES;

	// store step
	assign rcv_new  = alloc_q ? TW'(1) : slot_rcv_q[slot_q] + TW'(1);
	assign cmp_done = (rcv_new == slot_total_q[slot_q]);
	assign row_new  = (alloc_q ? '0 : map_rd_q) | (MAX_CHUNKS'(1) << cidx_q[CIW-1:0]);

	// allocation of a free slot or of the replaced oldest one
	assign alloc_slot = (state_q == S_ALLOC) ? free_q : old_q;
	assign do_alloc   = ((state_q == S_ALLOC) && free_found_q)
	                 || ((state_q == S_REPLACE) && u_lt);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (func_q == FUNC_CONSUME)  state_d = S_DONE;
				else if (psize_q < HDR_BYTES) state_d = S_DONE;
				else if (u_lt)               state_d = S_EVICT;
				else if (u_over)             state_d = S_DONE;
				else                         state_d = S_FIND;
			end
			S_EVICT: begin
				if (last) state_d = S_FIND;
			end
			S_FIND: begin
				if (last) state_d = S_INDEX;
			end
			S_INDEX: begin
				if (idx_bad)      state_d = S_DONE;
				else if (found_q) state_d = S_DUP;
				else              state_d = S_ALLOC;
			end
			S_DUP: begin
				state_d = map_rd_q[cidx_q[CIW-1:0]] ? S_DONE : S_STORE;
			end
			S_ALLOC: begin
				state_d = free_found_q ? S_STORE : S_OLDEST;
			end
			S_OLDEST: begin
				if (last) state_d = S_REPLACE;
			end
			S_REPLACE: begin
				state_d = u_lt ? S_STORE : S_DONE;
			end
			S_STORE: begin
				state_d = cmp_done ? S_FREE : S_DONE;
			end
			S_FREE: begin
				if (last) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers: slot occupancy, newest id, pending display, config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			in_use_q    <= '0;
			newest_q    <= 32'd0;
			pend_flag_q <= 1'b0;
			pend_id_q   <= 32'd0;
			win_q       <= STALE_WINDOW_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) win_q <= pwdata[1:0];
			// output register filled by the done step, emptied when taken
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CHECK: begin
					idx_q <= '0;
					if (func_q == FUNC_CONSUME) begin
						pend_flag_q <= 1'b0;
					end else if (psize_q >= HDR_BYTES && u_lt) begin
						newest_q <= fid_q;
					end
				end
				S_EVICT: begin
					// slot lags the new newest id by more than the window
					if (in_use_q[idx_q] && u_over) in_use_q[idx_q] <= 1'b0;
					idx_q <= last ? '0 : idx_q + SW'(1);
				end
				S_FIND, S_OLDEST: begin
					idx_q <= last ? '0 : idx_q + SW'(1);
				end
				S_ALLOC, S_REPLACE: begin
					idx_q <= '0;
					if (do_alloc) in_use_q[alloc_slot] <= 1'b1;
				end
				S_STORE: begin
					idx_q <= '0;
					// newest completed frame wins the display
					if (cmp_done && (!pend_flag_q || u_lt)) begin
						pend_flag_q <= 1'b1;
						pend_id_q   <= fid_q;
					end
				end
				S_FREE: begin
					// release this frame and every older one
					if (in_use_q[idx_q] && (u_lt || u_eq)) in_use_q[idx_q] <= 1'b0;
					idx_q <= last ? '0 : idx_q + SW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					func_q  <= chunk.func;
					fid_q   <= chunk.frame_num;
					cidx_q  <= chunk.chunk_index;
					total_q <= chunk.chunk_total;
					plen_q  <= chunk.claimed_len;
					psize_q <= chunk.packet_size;
				end
			end
			S_CHECK: begin
				res_done_q   <= 1'b0;
				res_upd_q    <= 1'b0;
				slot_q       <= '0;
				len_q        <= 16'd0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				if (func_q == FUNC_CONSUME)   res_verdict_q <= V_CONSUMED;
				else if (psize_q < HDR_BYTES) res_verdict_q <= V_SHORT;
				else                          res_verdict_q <= V_STALE;
			end
			S_FIND: begin
				if (in_use_q[idx_q] && u_eq && !found_q) begin
					found_q <= 1'b1;
					slot_q  <= idx_q;
				end
				if (!in_use_q[idx_q] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q       <= idx_q;
				end
			end
			S_INDEX: begin
				if (idx_bad) res_verdict_q <= V_BAD_INDEX;
				// clamp the claimed length to what was received
				len_q <= ((|plen_q[31:16]) || (plen_q[15:0] > room)) ? room : plen_q[15:0];
			end
			S_DUP: begin
				alloc_q <= 1'b0;
				if (map_rd_q[cidx_q[CIW-1:0]]) res_verdict_q <= V_DUPLICATE;
			end
			S_OLDEST: begin
				if (idx_q == '0 || u_lt) begin
					old_q    <= idx_q;
					oldest_q <= slot_fid_q[idx_q];
				end
			end
			S_STORE: begin
				slot_rcv_q[slot_q] <= rcv_new;
				if (cmp_done) begin
					res_verdict_q <= V_COMPLETE;
					res_done_q    <= 1'b1;
					res_upd_q     <= !pend_flag_q || u_lt;
				end else begin
					res_verdict_q <= V_STORED;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_verdict_q <= res_verdict_q;
					out_slot_q    <= (res_verdict_q == V_STORED || res_verdict_q == V_COMPLETE)
					                 ? slot_q : '0;
					out_len_q     <= (res_verdict_q == V_STORED || res_verdict_q == V_COMPLETE)
					                 ? len_q : 16'd0;
					out_done_q    <= res_done_q;
					out_upd_q     <= res_upd_q;
					out_pend_q    <= pend_flag_q;
					out_pend_id_q <= pend_id_q;
				end
			end
			default: begin
			end
		endcase
		if (do_alloc) begin
			slot_q                   <= alloc_slot;
			alloc_q                  <= 1'b1;
			slot_fid_q[alloc_slot]   <= fid_q;
			slot_total_q[alloc_slot] <= TW'(total_q);
		end
	end

	// bitmap memory: registered read at the current slot, write on store
	always_ff @(posedge clk) begin
		map_rd_q <= map_mem[slot_q];
		if (state_q == S_STORE) map_mem[slot_q] <= row_new;
	end

	assign result.valid            = out_valid_q;
	assign result.verdict          = out_verdict_q;
	assign result.slot             = 2'(out_slot_q);
	assign result.stored_length    = out_len_q;
	assign result.frame_done       = out_done_q;
	assign result.display_updated  = out_upd_q;
	assign result.pending_valid    = out_pend_q;
	assign result.pending_num      = out_pend_id_q;

`ifndef NO_ASSERTIONS
	// a consume request always leaves the pending flag clear
	a_consume_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && func_q == FUNC_CONSUME) |=> !pend_flag_q)
		else $error("pending flag survived a consume");

	// frame_done goes with the completed verdict and nothing else
	a_done_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.frame_done == (result.verdict == V_COMPLETE)))
		else $error("frame_done disagrees with verdict");

	// a display update means a frame is now pending
	a_update_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.display_updated) |-> result.pending_valid)
		else $error("display update without a pending frame");

	// rejected items carry no slot and no length
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.verdict != V_STORED && result.verdict != V_COMPLETE)
		|-> (result.slot == 2'd0 && result.stored_length == 16'd0))
		else $error("rejected item carries slot or length");

	// a completing chunk releases its own slot during the release walk
	a_free_own: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE && last) |=> !in_use_q[slot_q])
		else $error("completed slot still in use");
`endif

endmodule
`default_nettype wire

@@ sim/chunk_reassembly_tracker_tb.sv @@
// self-checking testbench of the chunk reassembly tracker
`default_nettype none
module chunk_reassembly_tracker_tb;
	import crt_pkg::*;

	localparam int SLOT_COUNT   = SLOTS;
	localparam int MAX_CHUNKS   = 64;
	localparam int CIW          = $clog2(MAX_CHUNKS);
	// longest item: newer frame id, all slots busy, completing chunk
	localparam int ITEM_CYCLES  = 4 * SLOT_COUNT + 7;
	localparam int SETTLE       = ITEM_CYCLES + 10;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 425;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam logic [2:0] ADDR_STALE_WINDOW = {REG_STALE_WINDOW, 2'b00};

	typedef struct packed {
		logic        func;
		logic [31:0] frame_num;
		logic [15:0] chunk_index;
		logic [15:0] chunk_total;
		logic [31:0] claimed_len;
		logic [15:0] packet_size;
	} chunk_hdr_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [1:0]  slot;
		logic [15:0] stored_length;
		logic        frame_done;
		logic        display_updated;
		logic        pending_valid;
		logic [31:0] pending_num;
	} tracker_out_t;

	logic clk = 1'b0;
	logic arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	crt_in_if  chunk ();
	crt_out_if result ();

	chunk_reassembly_tracker #(
		.MAX_CHUNKS(MAX_CHUNKS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chunk  (chunk),
		.result (result),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #1 clk = ~clk;

	// headers waiting to be offered, and outcomes waiting to come back
	chunk_hdr_t   hdr_q[$];
	tracker_out_t outcome_q[$];

	int          send_idle_pct;
	int          recv_idle_pct;
	int          stalls_asked;
	int          stalls_served;
	int          hold_left;
	int          hdr_count;
	int          result_count;
	int          mismatches;
	int unsigned cycle_count;
	logic [31:0] frame_cursor;

	// ---------------------------------------------------------------
	// shadow copy of the tracker state
	// ---------------------------------------------------------------
	logic [1:0]            stale_win;
	logic [31:0]           newest_id;
	logic                  slot_busy [SLOT_COUNT];
	logic [31:0]           slot_fid  [SLOT_COUNT];
	int                    slot_tot  [SLOT_COUNT];
	int                    slot_got  [SLOT_COUNT];
	logic [MAX_CHUNKS-1:0] slot_map  [SLOT_COUNT];
	logic                  pend_flag;
	logic [31:0]           pend_id;

	// works out the outcome of one accepted header and moves the shadow state on
	function automatic tracker_out_t track_chunk(chunk_hdr_t h);
		tracker_out_t r;
		int s;
		int old;
		int i;
		logic [31:0] tot;
		logic [15:0] room;
		r = '0;
		r.verdict = V_SHORT;
		if (h.func == FUNC_CONSUME) begin
			pend_flag = 1'b0;
			r.verdict = V_CONSUMED;
		end else if (h.packet_size >= HDR_BYTES) begin
			// a newer frame id moves the horizon and drops lagging assemblies,
			// even when this chunk is turned away afterwards
			if (h.frame_num > newest_id) begin
				newest_id = h.frame_num;
				for (i = 0; i < SLOT_COUNT; i++)
					if (slot_busy[i] && newest_id - slot_fid[i] > 32'(stale_win))
						slot_busy[i] = 1'b0;
			end
			if (newest_id - h.frame_num > 32'(stale_win)) begin
				r.verdict = V_STALE;
			end else begin
				s = -1;
				for (i = SLOT_COUNT - 1; i >= 0; i--)
					if (slot_busy[i] && slot_fid[i] == h.frame_num)
						s = i;
				// a known frame keeps the total of its first chunk
				tot = (s >= 0) ? 32'(slot_tot[s]) : 32'(h.chunk_total);
				if (tot > MAX_CHUNKS || h.chunk_index >= tot || h.chunk_index >= MAX_CHUNKS) begin
					r.verdict = V_BAD_INDEX;
				end else if (s >= 0 && slot_map[s][h.chunk_index[CIW-1:0]]) begin
					r.verdict = V_DUPLICATE;
				end else begin
					if (s < 0) begin
						for (i = SLOT_COUNT - 1; i >= 0; i--)
							if (!slot_busy[i])
								s = i;
						// all slots busy: take over the oldest if it is older than us
						if (s < 0) begin
							old = 0;
							for (i = 1; i < SLOT_COUNT; i++)
								if (slot_fid[i] < slot_fid[old])
									old = i;
							if (slot_fid[old] < h.frame_num)
								s = old;
						end
						if (s >= 0) begin
							slot_busy[s] = 1'b1;
							slot_fid[s]  = h.frame_num;
							slot_tot[s]  = int'(tot);
							slot_got[s]  = 0;
							slot_map[s]  = '0;
						end
					end
					if (s < 0) begin
						r.verdict = V_STALE;
					end else begin
						room = h.packet_size - HDR_BYTES;
						r.stored_length = (h.claimed_len > 32'(room)) ? room : h.claimed_len[15:0];
						r.slot = 2'(s);
						slot_map[s][h.chunk_index[CIW-1:0]] = 1'b1;
						slot_got[s]++;
						r.verdict = V_STORED;
						if (slot_got[s] == slot_tot[s]) begin
							r.verdict = V_COMPLETE;
							r.frame_done = 1'b1;
							// newest completed frame wins the display
							if (!pend_flag || h.frame_num > pend_id) begin
								pend_id = h.frame_num;
								pend_flag = 1'b1;
								r.display_updated = 1'b1;
							end
							for (i = 0; i < SLOT_COUNT; i++)
								if (slot_busy[i] && slot_fid[i] <= h.frame_num)
									slot_busy[i] = 1'b0;
						end
					end
				end
			end
		end
		r.pending_valid = pend_flag;
		r.pending_num = pend_id;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// header generation
	// ---------------------------------------------------------------
	function automatic chunk_hdr_t hdr(logic f, logic [31:0] fid, logic [15:0] idx,
			logic [15:0] tot, logic [31:0] plen, logic [15:0] psize);
		chunk_hdr_t c;
		c.func = f;
		c.frame_num = fid;
		c.chunk_index = idx;
		c.chunk_total = tot;
		c.claimed_len = plen;
		c.packet_size = psize;
		return c;
	endfunction

	function automatic void push_hdr(chunk_hdr_t c);
		hdr_q.push_back(c);
		hdr_count++;
	endfunction

	function automatic logic [15:0] rand_packet_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 4)
			return HDR_BYTES;
		if (roll < 14)
			return 16'($urandom_range(65535, 12));
		return 16'($urandom_range(1500, 12));
	endfunction

	function automatic logic [31:0] rand_payload_len();
		int roll;
		roll = $urandom_range(99);
		if (roll < 25)
			return $urandom_range(16);
		if (roll < 75)
			return $urandom_range(1600);
		return $urandom;
	endfunction

	// a chunk of a well-formed frame, now and then with a wrong total or index
	function automatic chunk_hdr_t frame_chunk(logic [31:0] fid, int idx, int tot);
		int roll;
		logic [15:0] t;
		logic [15:0] k;
		roll = $urandom_range(99);
		t = 16'(tot);
		k = 16'(idx);
		if (roll < 8)
			t = 16'($urandom_range(65535));
		else if (roll < 11)
			k = 16'(tot + $urandom_range(3));
		return hdr(FUNC_CHUNK, fid, k, t, rand_payload_len(), rand_packet_size());
	endfunction

	// one to three neighbouring frames, chunks lost, repeated and mixed at random
	task automatic gen_burst();
		chunk_hdr_t parts[$];
		chunk_hdr_t c;
		chunk_hdr_t tmp;
		int frames;
		int tot;
		int j;
		int k;
		int pick;
		frames = $urandom_range(3, 1);
		for (j = 0; j < frames; j++) begin
			tot = ($urandom_range(99) < 6) ? $urandom_range(MAX_CHUNKS, 7) : $urandom_range(6, 1);
			for (k = 0; k < tot; k++) begin
				if ($urandom_range(99) < 5)
					continue;
				c = frame_chunk(frame_cursor + j, k, tot);
				parts.push_back(c);
				if ($urandom_range(99) < 5)
					parts.push_back(c);
			end
		end
		if ($urandom_range(99) < 65) begin
			for (j = parts.size() - 1; j > 0; j--) begin
				pick = $urandom_range(j);
				tmp = parts[j];
				parts[j] = parts[pick];
				parts[pick] = tmp;
			end
		end
		foreach (parts[j])
			push_hdr(parts[j]);
		frame_cursor = frame_cursor + frames + $urandom_range(1);
	endtask

	task automatic gen_traffic(int n);
		int start;
		int roll;
		start = hdr_count;
		while (hdr_count - start < n) begin
			roll = $urandom_range(99);
			if (roll < 60) begin
				gen_burst();
			end else if (roll < 80) begin
				// consume: the other fields carry noise
				push_hdr(hdr(FUNC_CONSUME, $urandom, 16'($urandom), 16'($urandom),
					$urandom, 16'($urandom)));
			end else if (roll < 87) begin
				push_hdr(hdr(FUNC_CHUNK, $urandom, 16'($urandom), 16'($urandom),
					$urandom, 16'($urandom_range(HDR_BYTES - 1))));
			end else if (roll < 93 && frame_cursor > 100) begin
				// a frame well behind the newest
				push_hdr(hdr(FUNC_CHUNK, frame_cursor - $urandom_range(60, 4),
					16'($urandom_range(3)), 16'($urandom_range(6, 1)),
					rand_payload_len(), rand_packet_size()));
			end else begin
				// index and total anywhere in their range
				push_hdr(hdr(FUNC_CHUNK, frame_cursor, 16'($urandom), 16'($urandom),
					rand_payload_len(), rand_packet_size()));
			end
		end
	endtask

	task automatic load_directed();
		// consume with nothing pending
		push_hdr(hdr(FUNC_CONSUME, 32'd0, 16'd0, 16'd0, 32'd0, 16'd0));
		// short packets, one just below the header size
		push_hdr(hdr(FUNC_CHUNK, 32'd10, 16'd0, 16'd2, 32'd100, HDR_BYTES - 16'd1));
		push_hdr(hdr(FUNC_CHUNK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd0));
		// bad index: zero total, total beyond the bitmap, index at the limit, index at total
		push_hdr(hdr(FUNC_CHUNK, 32'd10, 16'd0, 16'd0, 32'd1, HDR_BYTES));
		push_hdr(hdr(FUNC_CHUNK, 32'd10, 16'd0, 16'(MAX_CHUNKS + 1), 32'd1, HDR_BYTES));
		push_hdr(hdr(FUNC_CHUNK, 32'd10, 16'(MAX_CHUNKS), 16'(MAX_CHUNKS), 32'd1, HDR_BYTES));
		push_hdr(hdr(FUNC_CHUNK, 32'd10, 16'd2, 16'd2, 32'd1, HDR_BYTES));
		// largest packet, length clamped
		push_hdr(hdr(FUNC_CHUNK, 32'd10, 16'd0, 16'd2, 32'hFFFF_FFFF, 16'hFFFF));
		push_hdr(hdr(FUNC_CHUNK, 32'd10, 16'd0, 16'd2, 32'd3, 16'd100));
		// total mismatch ignored, frame completes
		push_hdr(hdr(FUNC_CHUNK, 32'd10, 16'd1, 16'd99, 32'd0, HDR_BYTES));
		// older frame completes, display keeps the newer one
		push_hdr(hdr(FUNC_CHUNK, 32'd8, 16'd0, 16'd1, 32'd7, HDR_BYTES));
		// fill all four slots
		push_hdr(hdr(FUNC_CHUNK, 32'd11, 16'd0, 16'd3, 32'd5, 16'd40));
		push_hdr(hdr(FUNC_CHUNK, 32'd12, 16'd0, 16'd3, 32'd50, 16'd40));
		push_hdr(hdr(FUNC_CHUNK, 32'd13, 16'd0, 16'd3, 32'd20, 16'd32));
		push_hdr(hdr(FUNC_CHUNK, 32'd14, 16'd0, 16'd3, 32'd9, 16'd64));
		push_hdr(hdr(FUNC_CHUNK, 32'd12, 16'd0, 16'd3, 32'd9, 16'd64));
		push_hdr(hdr(FUNC_CHUNK, 32'd9, 16'd0, 16'd3, 32'd9, 16'd64));
		push_hdr(hdr(FUNC_CHUNK, 32'd13, 16'd3, 16'd64, 32'd9, 16'd64));
		push_hdr(hdr(FUNC_CHUNK, 32'd12, 16'd1, 16'd3, 32'd9, 16'd64));
		push_hdr(hdr(FUNC_CHUNK, 32'd12, 16'd2, 16'd3, 32'd9, 16'd64));
		// newer frame drops the lagging assemblies
		push_hdr(hdr(FUNC_CHUNK, 32'd18, 16'd0, 16'd2, 32'd9, 16'd64));
		push_hdr(hdr(FUNC_CONSUME, 32'd0, 16'd0, 16'd0, 32'd0, 16'd0));
		push_hdr(hdr(FUNC_CHUNK, 32'd16, 16'd0, 16'd1, 32'd9, 16'd64));
		push_hdr(hdr(FUNC_CONSUME, 32'd0, 16'd0, 16'd0, 32'd0, 16'd0));
	endtask

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatches++;
		if (mismatches <= 100)
			$display("item %0d %s: got 0x%0h, expected 0x%0h", result_count, what, got, want);
	endtask

	// ---------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------
	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_check(logic [2:0] addr, logic [31:0] want);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			report_mismatch("stale_window readback", prdata, want);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// everything offered has been taken and every outcome has come back
	task automatic drain();
		while (hdr_q.size() != 0 || chunk.valid || outcome_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(logic [1:0] win, int send_pct, int recv_pct,
			bit jump, logic [31:0] cursor, bit with_stall);
		apb_write(ADDR_STALE_WINDOW, 32'(win));
		stale_win = win;
		apb_check(ADDR_STALE_WINDOW, 32'(win));
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		if (jump)
			frame_cursor = cursor;
		gen_traffic(PHASE_ITEMS);
		// long receiver hold-off while the sender keeps offering
		if (with_stall)
			stalls_asked++;
		drain();
	endtask

	// ---------------------------------------------------------------
	// sender: offers queued headers, predicts each one as it is taken
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_chunks
		chunk_hdr_t taken;
		chunk_hdr_t nxt;
		if (!arst_n) begin
			chunk.valid <= 1'b0;
		end else begin
			if (chunk.valid && chunk.ready) begin
				taken.func = chunk.func;
				taken.frame_num = chunk.frame_num;
				taken.chunk_index = chunk.chunk_index;
				taken.chunk_total = chunk.chunk_total;
				taken.claimed_len = chunk.claimed_len;
				taken.packet_size = chunk.packet_size;
				outcome_q.push_back(track_chunk(taken));
			end
			if (chunk.valid && !chunk.ready) begin
				// hold the item until it is taken
			end else if (hdr_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = hdr_q.pop_front();
				chunk.func         <= nxt.func;
				chunk.frame_num    <= nxt.frame_num;
				chunk.chunk_index  <= nxt.chunk_index;
				chunk.chunk_total  <= nxt.chunk_total;
				chunk.claimed_len  <= nxt.claimed_len;
				chunk.packet_size  <= nxt.packet_size;
				chunk.valid        <= 1'b1;
			end else begin
				chunk.valid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure, plus the long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready  <= 1'b0;
			hold_left     <= 0;
			stalls_served <= 0;
		end else if (stalls_served != stalls_asked) begin
			stalls_served <= stalls_asked;
			hold_left     <= HOLD_CYCLES;
			result.ready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result checker: oldest outcome first, field by field
	always @(posedge clk) begin : check_results
		tracker_out_t want;
		if (arst_n && result.valid && result.ready) begin
			result_count++;
			if (outcome_q.size() == 0) begin
				report_mismatch("result with nothing outstanding", result.verdict, 0);
			end else begin
				want = outcome_q.pop_front();
				if (result.verdict !== want.verdict)
					report_mismatch("verdict", result.verdict, want.verdict);
				if (result.slot !== want.slot)
					report_mismatch("slot", result.slot, want.slot);
				if (result.stored_length !== want.stored_length)
					report_mismatch("stored_length", result.stored_length, want.stored_length);
				if (result.frame_done !== want.frame_done)
					report_mismatch("frame_done", result.frame_done, want.frame_done);
				if (result.display_updated !== want.display_updated)
					report_mismatch("display_updated", result.display_updated,
						want.display_updated);
				if (result.pending_valid !== want.pending_valid)
					report_mismatch("pending_valid", result.pending_valid, want.pending_valid);
				if (result.pending_num !== want.pending_num)
					report_mismatch("pending_num", result.pending_num,
						want.pending_num);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// sequence of the run
	// ---------------------------------------------------------------
	initial begin : run
		int i;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		chunk.valid = 1'b0;
		chunk.func = FUNC_CHUNK;
		chunk.frame_num = '0;
		chunk.chunk_index = '0;
		chunk.chunk_total = '0;
		chunk.claimed_len = '0;
		chunk.packet_size = '0;
		result.ready = 1'b0;
		cycle_count = 0;
		stalls_asked = 0;
		hdr_count = 0;
		result_count = 0;
		mismatches = 0;
		send_idle_pct = 18;
		recv_idle_pct = 49;
		// shadow state as after reset
		stale_win = STALE_WINDOW_RESET;
		newest_id = '0;
		pend_flag = 1'b0;
		pend_id = '0;
		for (i = 0; i < SLOT_COUNT; i++) begin
			slot_busy[i] = 1'b0;
			slot_fid[i] = '0;
			slot_tot[i] = 0;
			slot_got[i] = 0;
			slot_map[i] = '0;
		end
		load_directed();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		drain();
		frame_cursor = 32'd1000;
		// window, sender idle %, receiver idle %, cursor jump, long hold-off
		run_phase(2'd0, 18, 49, 1'b0, 32'd0, 1'b0);
		run_phase(2'd2, 49, 18, 1'b0, 32'd0, 1'b0);
		run_phase(2'd3, 0, 0, 1'b1, 32'h8000_0000 + $urandom_range(1 << 20), 1'b1);
		run_phase(2'd1, 0, 0, 1'b1, 32'hFFFF_F000, 1'b0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ chunk_reassembly_tracker.f @@
rtl/crt_pkg.sv
rtl/crt_in_if.sv
rtl/crt_out_if.sv
rtl/chunk_reassembly_tracker.sv
sim/chunk_reassembly_tracker_tb.sv
